@@ rtl/core/bblc_pkg.sv @@
// Shared types and codes for the byte-budget LRU block cache.
package bblc_pkg;

   localparam int KEY_W    = 64;
   localparam int SIZE_W   = 21;
   localparam int REF_W    = 32;
   localparam int CAP_W    = 32;
   localparam int USED_W   = 33;
   localparam int CNT_W    = 48;
   localparam int ENTRY_W  = 7;
   localparam int FUNC_W   = 2;
   localparam int REQ_W    = 184;
   localparam int RSP_W    = 192;

   // Operation codes carried on the request tuser
   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOOKUP = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_TRIM   = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_EXEC,
      ST_EVICT,
      ST_INSERT,
      ST_TRIM,
      ST_DONE
   } state_type;

   // Commands broadcast along the cell row
   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_MATCH,
      CMD_FRONT,
      CMD_UPDATE,
      CMD_DROP_MATCH,
      CMD_DROP_RANK,
      CMD_INSERT
   } cmd_type;

   // Status a cell reports back to the controller
   typedef struct packed {
      logic              match;
      logic [SIZE_W-1:0] m_size;
      logic [REF_W-1:0]  m_ref;
      logic [SIZE_W-1:0] o_size;
   } cell_stat_type;

endpackage

@@ rtl/core/byte_budget_lru_block_cache.sv @@
// Byte-budget LRU block cache: slot cell row and operation sequencer.
// Sequence: every request passes the match and exec states and ends in the done state;
// a fitting replace or a trim also passes trim, a fitting new-key insert passes insert
// (after evict when full) and then trim. One request at a time, taken only when idle.
// Reset: synchronous, active high; clears slot valid bits, byte/entry totals and
// counters, and sets capacity to 1048576. No clearing pass is needed.
module byte_budget_lru_block_cache import bblc_pkg::*; #(
   parameter int     SLOTS           = 64,
   parameter longint MAX_BLOCK_BYTES = 1048576
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // file_id[63:0], offset[127:64], block_size[148:128], block_handle[180:149]
   input  logic [REQ_W-1:0]  req_tdata,
   // func[1:0]
   input  logic [FUNC_W-1:0] req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // found_handle[31:0], found_size[52:32], bytes_in_use[84:53],
   // entries_in_use[91:85], hits_total[139:92], misses_total[187:140]
   output logic [RSP_W-1:0]  rsp_tdata,
   // hit[0]
   output logic              rsp_tuser,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CAP_W-1:0]  csr_data
);

   localparam int RW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   state_type         state_ff, state_in;
   func_type          func_ff, func_in;
   logic [KEY_W-1:0]  file_ff, file_in;
   logic [KEY_W-1:0]  offset_ff, offset_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [REF_W-1:0]  ref_ff, ref_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]  hits_ff, hits_in;
   logic [CNT_W-1:0]  miss_ff, miss_in;
   logic              hit_ff, hit_in;
   logic [REF_W-1:0]  fh_ff, fh_in;
   logic [SIZE_W-1:0] fs_ff, fs_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;
   logic              rsp_hit_ff, rsp_hit_in;

   cmd_type           cmd_op;
   logic [RW-1:0]     cmd_rank;
   logic [SLOTS:0]    free_chain;
   logic [SLOTS-1:0]  valid_vec;
   logic [SLOTS-1:0]  match_vec;
   logic [RW-1:0]     rank_vec [SLOTS];
   cell_stat_type     stat_vec [SLOTS];
   logic              any_match;
   logic [RW-1:0]     m_rank;
   logic [SIZE_W-1:0] m_size;
   logic [REF_W-1:0]  m_ref;
   logic [SIZE_W-1:0] o_size;
   logic              too_big;
   logic              over_cap;
   logic [ENTRY_W-1:0] entries;
   logic [RW-1:0]     oldest_rank;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign free_chain[0] = 1'b0;

   // Row of slot cells
   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      bblc_cell #(.RW(RW)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd_op     (cmd_op),
         .cmd_rank   (cmd_rank),
         .key_file   (file_ff),
         .key_offset (offset_ff),
         .wr_size    (size_ff),
         .wr_ref     (ref_ff),
         .free_in    (free_chain[g]),
         .free_out   (free_chain[g+1]),
         .valid_out  (valid_vec[g]),
         .m_rank     (rank_vec[g]),
         .stat       (stat_vec[g])
      );
      assign match_vec[g] = stat_vec[g].match;
   end

   // Collect gated cell status
   always_comb begin
      m_rank = '0;
      m_size = '0;
      m_ref  = '0;
      o_size = '0;
      for (int i = 0; i < SLOTS; i++) begin
         m_rank = m_rank | rank_vec[i];
         m_size = m_size | stat_vec[i].m_size;
         m_ref  = m_ref | stat_vec[i].m_ref;
         o_size = o_size | stat_vec[i].o_size;
      end
   end

   assign any_match   = |match_vec;
   assign too_big     = (size_ff > cap_ff[SIZE_W-1:0] && cap_ff < CAP_W'(1 << SIZE_W)) ||
                        ({11'b0, size_ff} > CAP_W'(MAX_BLOCK_BYTES));
   assign over_cap    = used_ff > {1'b0, cap_ff};
   assign oldest_rank = RW'(count_ff - 1'b1);
   assign entries     = (count_ff > CW'(127)) ? ENTRY_W'(127) : ENTRY_W'(count_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_MATCH;
         ST_MATCH: state_in = ST_EXEC;
         ST_EXEC: begin
            case (func_ff)
               FUNC_INSERT: begin
                  if (any_match) state_in = too_big ? ST_DONE : ST_TRIM;
                  else if (too_big) state_in = ST_DONE;
                  else if (count_ff == SLOTS_C) state_in = ST_EVICT;
                  else state_in = ST_INSERT;
               end
               FUNC_TRIM: state_in = ST_TRIM;
               default:   state_in = ST_DONE;
            endcase
         end
         ST_EVICT:  state_in = ST_INSERT;
         ST_INSERT: state_in = ST_TRIM;
         ST_TRIM:   if (!(over_cap && count_ff != '0)) state_in = ST_DONE;
         ST_DONE:   if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs: row command and datapath updates
   always_comb begin
      cmd_op       = CMD_NOP;
      cmd_rank     = oldest_rank;
      func_in      = func_ff;
      file_in      = file_ff;
      offset_in    = offset_ff;
      size_in      = size_ff;
      ref_in       = ref_ff;
      cap_in       = (csr_valid && csr_ready) ? csr_data : cap_ff;
      used_in      = used_ff;
      count_in     = count_ff;
      hits_in      = hits_ff;
      miss_in      = miss_ff;
      hit_in       = hit_ff;
      fh_in        = fh_ff;
      fs_in        = fs_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_hit_in   = rsp_hit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in   = func_type'(req_tuser);
               file_in   = req_tdata[63:0];
               offset_in = req_tdata[127:64];
               size_in   = req_tdata[148:128];
               ref_in    = req_tdata[180:149];
               hit_in    = 1'b0;
               fh_in     = '0;
               fs_in     = '0;
            end
         end
         ST_MATCH: cmd_op = CMD_MATCH;
         ST_EXEC: begin
            cmd_rank = m_rank;
            case (func_ff)
               FUNC_LOOKUP: begin
                  if (any_match) begin
                     cmd_op = CMD_FRONT;
                     hit_in = 1'b1;
                     fh_in  = m_ref;
                     fs_in  = m_size;
                     if (hits_ff != CNT_MAX) hits_in = hits_ff + 1'b1;
                  end else if (miss_ff != CNT_MAX) begin
                     miss_in = miss_ff + 1'b1;
                  end
               end
               FUNC_INSERT: begin
                  if (any_match) begin
                     if (too_big) begin
                        cmd_op   = CMD_DROP_MATCH;
                        used_in  = used_ff - USED_W'(m_size);
                        count_in = count_ff - 1'b1;
                     end else begin
                        cmd_op  = CMD_UPDATE;
                        used_in = used_ff - USED_W'(m_size) + USED_W'(size_ff);
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_EVICT: begin
            cmd_op   = CMD_DROP_RANK;
            used_in  = used_ff - USED_W'(o_size);
            count_in = count_ff - 1'b1;
         end
         ST_INSERT: begin
            cmd_op   = CMD_INSERT;
            used_in  = used_ff + USED_W'(size_ff);
            count_in = count_ff + 1'b1;
         end
         ST_TRIM: begin
            if (over_cap && count_ff != '0) begin
               cmd_op   = CMD_DROP_RANK;
               used_in  = used_ff - USED_W'(o_size);
               count_in = count_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_data_in  = {4'b0, miss_ff, hits_ff, entries, used_ff[CAP_W-1:0],
                               fs_ff, fh_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_W'(1048576);
         used_ff      <= '0;
         count_ff     <= '0;
         hits_ff      <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         hits_ff      <= hits_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff     <= func_in;
      file_ff     <= file_in;
      offset_ff   <= offset_in;
      size_ff     <= size_in;
      ref_ff      <= ref_in;
      hit_ff      <= hit_in;
      fh_ff       <= fh_in;
      fs_ff       <= fs_in;
      rsp_data_ff <= rsp_data_in;
      rsp_hit_ff  <= rsp_hit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hit_ff;

`ifndef SYNTHESIS
   // Entry count tracks the valid bits of the row
   a_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == count_ff)
      else $error("entry count out of step with slot valid bits");

   // At most one slot matches a key
   a_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("duplicate key match");

   // Trim leaves the budget met or the table empty
   a_trim: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRIM && state_in == ST_DONE) |-> (!over_cap || count_ff == '0))
      else $error("trim ended over budget");

   // A result is issued only from the done state
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_DONE)
      else $error("result issued outside done state");
`endif

endmodule

@@ rtl/core/bblc_cell.sv @@
// One cache slot: key, size, handle and recency rank, plus free-slot chain.
module bblc_cell import bblc_pkg::*; #(
   parameter int RW = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd_op,
   input  logic [RW-1:0]     cmd_rank,
   input  logic [KEY_W-1:0]  key_file,
   input  logic [KEY_W-1:0]  key_offset,
   input  logic [SIZE_W-1:0] wr_size,
   input  logic [REF_W-1:0]  wr_ref,
   input  logic              free_in,     // some lower cell is free
   output logic              free_out,
   output logic              valid_out,
   output logic [RW-1:0]     m_rank,
   output cell_stat_type     stat
);

   logic              valid_ff, valid_in;
   logic              match_ff, match_in;
   logic [RW-1:0]     rank_ff, rank_in;
   logic [KEY_W-1:0]  file_ff, file_in;
   logic [KEY_W-1:0]  offset_ff, offset_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [REF_W-1:0]  ref_ff, ref_in;

   // Next slot contents per command
   always_comb begin
      valid_in  = valid_ff;
      match_in  = match_ff;
      rank_in   = rank_ff;
      file_in   = file_ff;
      offset_in = offset_ff;
      size_in   = size_ff;
      ref_in    = ref_ff;
      case (cmd_op)
         CMD_MATCH: begin
            match_in = valid_ff && (file_ff == key_file) && (offset_ff == key_offset);
         end
         CMD_FRONT, CMD_UPDATE: begin
            if (valid_ff && (rank_ff < cmd_rank)) rank_in = rank_ff + 1'b1;
            if (match_ff) begin
               rank_in = '0;
               if (cmd_op == CMD_UPDATE) begin
                  size_in = wr_size;
                  ref_in  = wr_ref;
               end
            end
         end
         CMD_DROP_MATCH: begin
            if (match_ff) begin
               valid_in = 1'b0;
               match_in = 1'b0;
            end else if (valid_ff && (rank_ff > cmd_rank)) begin
               rank_in = rank_ff - 1'b1;
            end
         end
         CMD_DROP_RANK: begin
            if (valid_ff && (rank_ff == cmd_rank)) begin
               valid_in = 1'b0;
               match_in = 1'b0;
            end
         end
         CMD_INSERT: begin
            if (valid_ff) begin
               rank_in = rank_ff + 1'b1;
            end else if (!free_in) begin
               valid_in  = 1'b1;
               rank_in   = '0;
               file_in   = key_file;
               offset_in = key_offset;
               size_in   = wr_size;
               ref_in    = wr_ref;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
      rank_ff   <= rank_in;
      file_ff   <= file_in;
      offset_ff <= offset_in;
      size_ff   <= size_in;
      ref_ff    <= ref_in;
   end

   // Gated outputs so the controller can OR them across the row
   assign free_out    = free_in || !valid_ff;
   assign valid_out   = valid_ff;
   assign m_rank      = match_ff ? rank_ff : '0;
   assign stat.match  = match_ff;
   assign stat.m_size = match_ff ? size_ff : '0;
   assign stat.m_ref  = match_ff ? ref_ff : '0;
   assign stat.o_size = (valid_ff && (rank_ff == cmd_rank)) ? size_ff : '0;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the byte-budget LRU block cache.
`timescale 1ns / 100ps

module tb_top;
   import bblc_pkg::*;

   localparam int NSLOT   = 64;
   localparam int MAXBLK  = 1048576;
   localparam logic [47:0] CNT_SAT = 48'hFFFF_FFFF_FFFF;

   typedef struct {
      func_type    op;
      logic [63:0] file_id;
      logic [63:0] offset;
      logic [20:0] size;
      logic [31:0] handle;
   } cache_req_type;

   typedef struct {
      logic        hit;
      logic [31:0] handle;
      logic [20:0] size;
      logic [31:0] bytes_used;
      logic [6:0]  entries;
      logic [47:0] hits;
      logic [47:0] misses;
   } cache_rsp_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic [FUNC_W-1:0] req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              rsp_tuser;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CAP_W-1:0]  csr_data = '0;

   byte_budget_lru_block_cache uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the cache contents
   logic        sh_valid [NSLOT];
   logic [63:0] sh_file  [NSLOT];
   logic [63:0] sh_off   [NSLOT];
   logic [20:0] sh_size  [NSLOT];
   logic [31:0] sh_ref   [NSLOT];
   int          sh_rank  [NSLOT];
   logic [32:0] sh_used;
   logic [47:0] sh_hits, sh_misses;
   logic [31:0] sh_cap;

   cache_req_type pending_reqs[$];
   cache_rsp_type expected_rsps[$];
   int  send_idle_pct = 0, recv_stall_pct = 0;
   int  fail_count = 0, rsp_count = 0, hit_seen = 0, evict_ops = 0;
   bit  drain_done = 0;
   bit  req_taken = 0;

   function automatic int find_key(logic [63:0] f, logic [63:0] o);
      for (int i = 0; i < NSLOT; i++)
         if (sh_valid[i] && sh_file[i] == f && sh_off[i] == o) return i;
      return -1;
   endfunction

   function automatic int live_count();
      int n;
      n = 0;
      for (int i = 0; i < NSLOT; i++) if (sh_valid[i]) n++;
      return n;
   endfunction

   function automatic void move_front(int s);
      int r;
      r = sh_rank[s];
      for (int i = 0; i < NSLOT; i++)
         if (sh_valid[i] && sh_rank[i] < r) sh_rank[i]++;
      sh_rank[s] = 0;
   endfunction

   function automatic void evict_slot(int s);
      int r;
      r = sh_rank[s];
      sh_used = sh_used - sh_size[s];
      sh_valid[s] = 1'b0;
      for (int i = 0; i < NSLOT; i++)
         if (sh_valid[i] && sh_rank[i] > r) sh_rank[i]--;
   endfunction

   function automatic int lru_slot();
      int best;
      best = -1;
      for (int i = 0; i < NSLOT; i++)
         if (sh_valid[i] && (best < 0 || sh_rank[i] > sh_rank[best])) best = i;
      return best;
   endfunction

   function automatic void fit_budget();
      int s;
      while (sh_used > {1'b0, sh_cap}) begin
         s = lru_slot();
         if (s < 0) break;
         evict_slot(s);
         evict_ops++;
      end
   endfunction

   function automatic void store_block(cache_req_type q);
      int  s, fr;
      bit  oversize;
      s = find_key(q.file_id, q.offset);
      oversize = (q.size > sh_cap) || (q.size > MAXBLK);
      if (s >= 0) begin
         if (oversize) begin
            evict_slot(s);
            return;
         end
         sh_used = sh_used - sh_size[s] + q.size;
         sh_size[s] = q.size;
         sh_ref[s] = q.handle;
         move_front(s);
         fit_budget();
         return;
      end
      if (oversize) return;
      if (live_count() >= NSLOT) evict_slot(lru_slot());
      fr = -1;
      for (int i = NSLOT - 1; i >= 0; i--) if (!sh_valid[i]) fr = i;
      for (int j = 0; j < NSLOT; j++) if (sh_valid[j]) sh_rank[j]++;
      sh_valid[fr] = 1'b1;
      sh_file[fr] = q.file_id;
      sh_off[fr] = q.offset;
      sh_size[fr] = q.size;
      sh_ref[fr] = q.handle;
      sh_rank[fr] = 0;
      sh_used = sh_used + q.size;
      fit_budget();
   endfunction

   // expected result of one accepted request
   function automatic cache_rsp_type cache_predict(cache_req_type q);
      cache_rsp_type r;
      int s;
      r = '{default: '0};
      case (q.op)
         FUNC_LOOKUP: begin
            s = find_key(q.file_id, q.offset);
            if (s >= 0) begin
               if (sh_hits != CNT_SAT) sh_hits++;
               move_front(s);
               r.hit = 1'b1;
               r.handle = sh_ref[s];
               r.size = sh_size[s];
            end else if (sh_misses != CNT_SAT) sh_misses++;
         end
         FUNC_INSERT: store_block(q);
         FUNC_TRIM:   fit_budget();
         default: ;
      endcase
      r.bytes_used = sh_used[31:0];
      r.entries = 7'(live_count());
      r.hits = sh_hits;
      r.misses = sh_misses;
      return r;
   endfunction

   // request transfers: taken at the rising edge, predicted in order
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_rsps.push_back(cache_predict(pending_reqs.pop_front()));
         req_taken = 1'b1;
      end
   end

   // driver: one request transfer at a time, changes at the falling edge
   always @(negedge clock) begin
      cache_req_type q;
      if (!reset) begin
         // a waiting request holds until its transfer
         if (!req_tvalid || req_taken) begin
            req_taken = 1'b0;
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               q = pending_reqs[0];
               req_tvalid <= 1'b1;
               req_tuser <= q.op;
               req_tdata <= {3'b0, q.handle, q.size, q.offset, q.file_id};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor: sample result transfers at the rising edge
   always @(posedge clock) begin
      cache_rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            $error("result transfer with nothing expected");
            fail_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_tuser) hit_seen++;
            if (rsp_tuser !== e.hit) begin
               $error("hit: expected %0h actual %0h", e.hit, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[31:0] !== e.handle) begin
               $error("found_handle: expected %0h actual %0h", e.handle, rsp_tdata[31:0]);
               fail_count++;
            end
            if (rsp_tdata[52:32] !== e.size) begin
               $error("found_size: expected %0h actual %0h", e.size, rsp_tdata[52:32]);
               fail_count++;
            end
            if (rsp_tdata[84:53] !== e.bytes_used) begin
               $error("bytes_in_use: expected %0h actual %0h", e.bytes_used,
                      rsp_tdata[84:53]);
               fail_count++;
            end
            if (rsp_tdata[91:85] !== e.entries) begin
               $error("entries_in_use: expected %0h actual %0h", e.entries,
                      rsp_tdata[91:85]);
               fail_count++;
            end
            if (rsp_tdata[139:92] !== e.hits) begin
               $error("hits_total: expected %0h actual %0h", e.hits, rsp_tdata[139:92]);
               fail_count++;
            end
            if (rsp_tdata[187:140] !== e.misses) begin
               $error("misses_total: expected %0h actual %0h", e.misses,
                      rsp_tdata[187:140]);
               fail_count++;
            end
         end
      end
   end

   // key pool: small so that hits, replaces and evictions are common
   logic [63:0] pool_file [16];
   logic [63:0] pool_off  [16];

   function automatic cache_req_type make_req(func_type op, int k, logic [20:0] sz);
      cache_req_type q;
      q.op = op;
      q.file_id = pool_file[k];
      q.offset = pool_off[k];
      q.size = sz;
      q.handle = $urandom;
      return q;
   endfunction

   function automatic cache_req_type random_req(int nkeys, int maxsz);
      cache_req_type q;
      int p;
      p = $urandom_range(99);
      q = make_req(p < 45 ? FUNC_LOOKUP : FUNC_INSERT, $urandom_range(nkeys - 1),
                   21'($urandom_range(maxsz)));
      if (p >= 92) q.op = FUNC_TRIM;
      if (p >= 97) q.op = FUNC_NONE;
      if (p == 96) begin
         q.file_id = {$urandom, $urandom};
         q.offset = {$urandom, $urandom};
      end
      if ($urandom_range(30) == 0) q.size = 21'($urandom) | 21'h100000;
      return q;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_capacity(logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sh_cap = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // phase list: capacity, key count, max size, item count, sender idle, receiver stall
   task automatic run_phase(logic [31:0] cap, int nkeys, int maxsz, int items,
                            int idle, int stall);
      cache_req_type q;
      write_capacity(cap);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < items; i++) pending_reqs.push_back(random_req(nkeys, maxsz));
      q = make_req(FUNC_TRIM, 0, 21'd0);
      pending_reqs.push_back(q);
      wait_drained();
   endtask

   initial begin
      cache_req_type q;
      for (int i = 0; i < 16; i++) begin
         pool_file[i] = {$urandom, $urandom};
         pool_off[i] = {$urandom, $urandom};
      end
      pool_file[0] = '0;  pool_off[0] = '0;
      pool_file[1] = '1;  pool_off[1] = '1;
      pool_file[2] = '1;  pool_off[2] = '0;
      for (int i = 0; i < NSLOT; i++) begin
         sh_valid[i] = 1'b0; sh_file[i] = '0; sh_off[i] = '0;
         sh_size[i] = '0; sh_ref[i] = '0; sh_rank[i] = 0;
      end
      sh_used = '0; sh_hits = '0; sh_misses = '0;
      sh_cap = 32'd1048576;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, every op, oversize, replace, unused code
      pending_reqs.push_back(make_req(FUNC_LOOKUP, 0, 21'd0));
      pending_reqs.push_back(make_req(FUNC_INSERT, 0, 21'd0));
      q = make_req(FUNC_INSERT, 1, 21'd1048576); q.handle = '1;
      pending_reqs.push_back(q);
      pending_reqs.push_back(make_req(FUNC_LOOKUP, 0, 21'd0));
      pending_reqs.push_back(make_req(FUNC_LOOKUP, 1, 21'd0));
      pending_reqs.push_back(make_req(FUNC_INSERT, 2, 21'h1FFFFF));
      pending_reqs.push_back(make_req(FUNC_INSERT, 2, 21'd1048577));
      pending_reqs.push_back(make_req(FUNC_INSERT, 2, 21'd5));
      pending_reqs.push_back(make_req(FUNC_INSERT, 2, 21'd7));
      pending_reqs.push_back(make_req(FUNC_INSERT, 1, 21'h1FFFFF));
      pending_reqs.push_back(make_req(FUNC_LOOKUP, 2, 21'd0));
      pending_reqs.push_back(make_req(FUNC_TRIM, 0, 21'd0));
      q = make_req(FUNC_NONE, 1, 21'h1FFFFF); q.handle = '1;
      pending_reqs.push_back(q);
      wait_drained();
      // capacity lowered: no eviction until trim
      write_capacity(32'd4);
      pending_reqs.push_back(make_req(FUNC_LOOKUP, 2, 21'd0));
      pending_reqs.push_back(make_req(FUNC_TRIM, 0, 21'd0));
      pending_reqs.push_back(make_req(FUNC_INSERT, 3, 21'd4));
      pending_reqs.push_back(make_req(FUNC_INSERT, 4, 21'd3));
      wait_drained();
      // table full: more distinct keys than slots with large capacity
      write_capacity('1);
      for (int i = 0; i < 70; i++) begin
         q = make_req(FUNC_INSERT, 0, 21'($urandom_range(MAXBLK)));
         q.file_id = 64'(i); q.offset = {$urandom, $urandom};
         pending_reqs.push_back(q);
      end
      pending_reqs.push_back(make_req(FUNC_LOOKUP, 0, 21'd0));
      wait_drained();

      run_phase(32'hFFFF_FFFF, 16, MAXBLK, 200, 0, 0);
      run_phase(32'd3000, 12, 1200, 200, 81, 0);
      run_phase(32'd0, 8, 4, 100, 0, 81);
      run_phase(32'd1048576, 16, MAXBLK, 200, 26, 26);
      run_phase(32'd20000, 10, 6000, 250, 0, 0);
      run_phase(32'd1, 6, 2, 100, 81, 81);
      run_phase(32'd500000, 16, 200000, 200, 26, 26);

      drain_done = 1;
      $display("run covered %0d results, %0d lookup hits, %0d budget evictions",
               rsp_count, hit_seen, evict_ops);
      $display("capacities from 0 to 2^32-1, table-full and oversize cases included");
      if (fail_count == 0)
         $display("byte_budget_lru_block_cache: match");
      else
         $display("byte_budget_lru_block_cache: mismatch");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      if (!drain_done) $display("byte_budget_lru_block_cache: mismatch");
      $finish;
   end

endmodule
